// File: rtl/core/rbc_pkg.sv
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared constants, round function and key step function of the Raiden block cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

    localparam int ROUNDS_DEF = 16;
    localparam int KEY_WORDS  = 4;
    localparam int WORD_W     = 32;
    localparam int KEY_IDX_W  = 2;
    localparam int MIX_LEFT   = 9;
    localparam int MIX_RIGHT  = 14;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rbc_round_fn(input word_t sk, input word_t b);
        word_t s;
        s = sk + b;
        return (s << MIX_LEFT) ^ ((sk - b) ^ (s >> MIX_RIGHT));
    endfunction

    function automatic word_t rbc_key_step(input word_t k0, input word_t k1,
                                           input word_t k2, input word_t k3);
        return (k0 + k1) + ((k2 + k3) ^ (k0 << k2[4:0]));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/raiden_block_cipher.sv
// ----------------------------------------------------------------------------
// raiden_block_cipher
// Raiden cipher on 64-bit blocks under a 128-bit key, one half round per
// pipeline stage, with a key schedule unit that refreshes the subkeys.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tuser: op; tdata: block_low, block_high
//  m_*       out        tdata: out_low, out_high
//  cfg_*     in         cfg_index: key word 0..3; cfg_data: key word value
//
//  A word passes the entry register and then the half-round stages on its way
//  to m_tvalid; a new word may enter every cycle unless s_tready is held low.
//  After reset and after every key write the schedule unit builds the
//  subkeys, one round a cycle; s_tready is low meanwhile.
//  A stall on m_tready freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module raiden_block_cipher #(
    parameter int ROUNDS = rbc_pkg::ROUNDS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [2*rbc_pkg::WORD_W-1:0]   s_tdata,   // block_low, block_high
    input  wire logic                           s_tuser,   // op
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [2*rbc_pkg::WORD_W-1:0]        m_tdata,   // out_low, out_high
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rbc_pkg::KEY_IDX_W-1:0]  cfg_index,
    input  wire logic [rbc_pkg::WORD_W-1:0]     cfg_data
);
    import rbc_pkg::*;

    localparam int NS    = 2 * ROUNDS;
    localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    word_t                 key_reg    [KEY_WORDS];
    word_t                 kwork_reg  [KEY_WORDS];
    word_t                 sub_reg    [ROUNDS];
    logic                  ks_busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [KEY_IDX_W-1:0]  kw_reg;
    word_t                 nk;
    logic                  cfg_wr;

    logic [NS:0]           v_reg;
    logic [NS:0]           op_reg;
    word_t                 a_reg      [NS+1];
    word_t                 c_reg      [NS+1];
    logic                  en;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign nk = rbc_key_step(kwork_reg[0], kwork_reg[1], kwork_reg[2], kwork_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i]   <= '0;
                kwork_reg[i] <= '0;
            end
            ks_busy_reg <= 1'b1;
            cnt_reg     <= '0;
            kw_reg      <= '0;
        end else if (cfg_wr) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                kwork_reg[i] <= (KEY_IDX_W'(i) == cfg_index) ? cfg_data : key_reg[i];
            end
            key_reg[cfg_index] <= cfg_data;
            ks_busy_reg        <= 1'b1;
            cnt_reg            <= '0;
            kw_reg             <= '0;
        end else if (ks_busy_reg) begin
            kwork_reg[kw_reg] <= nk;
            kw_reg            <= kw_reg + 1'b1;
            cnt_reg           <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROUNDS - 1)) begin
                ks_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ks_busy_reg && !cfg_wr) begin
            sub_reg[cnt_reg] <= nk;
        end
    end

    // Decryption runs with the two words swapped, so every stage has the
    // same shape and only the sign and the subkey order change.
    assign en       = !v_reg[NS] || m_tready;
    assign s_tready = en && !ks_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[0] <= s_tuser;
            if (s_tuser == OP_DECRYPT) begin
                a_reg[0] <= s_tdata[2*WORD_W-1:WORD_W];
                c_reg[0] <= s_tdata[WORD_W-1:0];
            end else begin
                a_reg[0] <= s_tdata[WORD_W-1:0];
                c_reg[0] <= s_tdata[2*WORD_W-1:WORD_W];
            end
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int RE = j / 2;
        localparam int RD = ROUNDS - 1 - j / 2;

        word_t sk;
        word_t f;
        word_t a_next;
        word_t c_next;
        logic  dec;

        assign dec = (op_reg[j] == OP_DECRYPT);
        assign sk  = dec ? sub_reg[RD] : sub_reg[RE];

        if ((j % 2) == 0) begin : g_even
            assign f      = rbc_round_fn(sk, c_reg[j]);
            assign a_next = dec ? a_reg[j] - f : a_reg[j] + f;
            assign c_next = c_reg[j];
        end else begin : g_odd
            assign f      = rbc_round_fn(sk, a_reg[j]);
            assign a_next = a_reg[j];
            assign c_next = dec ? c_reg[j] - f : c_reg[j] + f;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j+1] <= 1'b0;
            end else if (en) begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                op_reg[j+1] <= op_reg[j];
                a_reg[j+1]  <= a_next;
                c_reg[j+1]  <= c_next;
            end
        end
    end

    assign m_tvalid = v_reg[NS];
    assign m_tdata  = (op_reg[NS] == OP_DECRYPT) ? {a_reg[NS], c_reg[NS]}
                                                 : {c_reg[NS], a_reg[NS]};

    a_key_write_starts_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> ks_busy_reg)
        else $error("key write did not restart the key schedule");

    a_no_accept_while_schedule: assert property (@(posedge aclk) disable iff (!aresetn)
        ks_busy_reg |-> !s_tready)
        else $error("input accepted while subkeys are being built");

    a_entry_stage_tracks_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> (v_reg[0] == $past(s_tvalid && s_tready)))
        else $error("entry stage valid does not match the accepted word");

endmodule

`default_nettype wire
